// ===== sv/pre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pre_pkg
// Types and constants shared by the pose reprojection error unit.
// ----------------------------------------------------------------------------
package pre_pkg;

	typedef struct packed {
		logic signed [31:0] world_x;
		logic signed [31:0] world_y;
		logic signed [31:0] world_z;
		logic signed [31:0] image_x;
		logic signed [31:0] image_y;
		logic [15:0]        point_tag;
	} point_t;

	typedef struct packed {
		logic [63:0] squared_error;
		logic        behind_camera;
		logic [15:0] result_tag;
	} result_t;

	typedef enum logic [2:0] {
		REG_ROT_ROW_0 = 3'd0,
		REG_ROT_ROW_1 = 3'd1,
		REG_ROT_ROW_2 = 3'd2,
		REG_CENTER_X  = 3'd3,
		REG_CENTER_Y  = 3'd4,
		REG_CENTER_Z  = 3'd5,
		REG_FOCAL_X   = 3'd6,
		REG_FOCAL_Y   = 3'd7
	} cfg_reg_t;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 48;

	// projected pixel magnitude saturates at 2**QUOT_BITS
	localparam int QUOT_BITS = 62;
	// any error at or above 2**ERR_CLAMP_BITS saturates for every supported frac width
	localparam int ERR_CLAMP_BITS = 47;

	localparam logic [47:0] ROT_ROW_0_RST = 48'h0000_0000_4000;
	localparam logic [47:0] ROT_ROW_1_RST = 48'h0000_4000_0000;
	localparam logic [47:0] ROT_ROW_2_RST = 48'h4000_0000_0000;
	localparam logic [31:0] FOCAL_RST = 32'h0001_0000;

endpackage

// ===== sv/pose_reprojection_error_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_reprojection_error_unit
// Squared pinhole reprojection error of one 2D-3D correspondence against a
// programmable camera pose.
// ----------------------------------------------------------------------------
// An accepted item passes through stages 1 to 5, the divider and stages 7 to 11
// into the output register. Throughput: one item per cycle while the skid is empty;
// the 62-step restoring divider is fully pipelined, one quotient bit per stage.
// A two-entry output buffer (output register plus skid) lets the pipeline
// run while a result waits; the input stalls only while the skid is full.
// Reset clears valid bits and loads identity rotation, zero center, unit focals.
module pose_reprojection_error_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               point_valid,
	output logic                               point_stall,
	input  pre_pkg::point_t                    point,
	output logic                               result_valid,
	input  logic                               result_stall,
	output pre_pkg::result_t                   result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [pre_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pre_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int DW = 33;                     // world minus center
	localparam int MPW = 49;                    // rotation product
	localparam int PW = 51;                     // rotated coordinate
	localparam int ZW = 50;                     // depth and remainder magnitude
	localparam int QB = pre_pkg::QUOT_BITS;
	localparam int NW = 82;                     // focal times lateral coordinate
	localparam int EW = 65;                     // signed pixel error
	localparam int CB = pre_pkg::ERR_CLAMP_BITS;
	localparam int SQW = 2 * (CB + 1);          // one squared axis
	localparam int TW = SQW + 1;                // sum of both axes

	typedef struct packed {
		logic signed [31:0] image_x;
		logic signed [31:0] image_y;
		logic [15:0]        tag;
	} side_t;

	typedef struct packed {
		logic [1:0][ZW-1:0] rem;
		logic [1:0][QB-1:0] sh;
		logic [1:0]         ovf;
		logic [1:0]         neg;
		logic [ZW-1:0]      pz;
		logic               behind;
		side_t              side;
	} div_t;

	// configuration registers
	logic [47:0] rot_q [3];
	logic [31:0] center_q [3];
	logic [31:0] focal_q [2];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= pre_pkg::ROT_ROW_0_RST;
			rot_q[1] <= pre_pkg::ROT_ROW_1_RST;
			rot_q[2] <= pre_pkg::ROT_ROW_2_RST;
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			focal_q[0] <= pre_pkg::FOCAL_RST;
			focal_q[1] <= pre_pkg::FOCAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (pre_pkg::cfg_reg_t'(cfg_index))
				pre_pkg::REG_ROT_ROW_0: rot_q[0] <= cfg_data;
				pre_pkg::REG_ROT_ROW_1: rot_q[1] <= cfg_data;
				pre_pkg::REG_ROT_ROW_2: rot_q[2] <= cfg_data;
				pre_pkg::REG_CENTER_X:  center_q[0] <= cfg_data[31:0];
				pre_pkg::REG_CENTER_Y:  center_q[1] <= cfg_data[31:0];
				pre_pkg::REG_CENTER_Z:  center_q[2] <= cfg_data[31:0];
				pre_pkg::REG_FOCAL_X:   focal_q[0] <= cfg_data[31:0];
				pre_pkg::REG_FOCAL_Y:   focal_q[1] <= cfg_data[31:0];
			endcase
		end
	end

	// whole pipeline advances unless the skid holds an item
	logic skid_v_q;
	logic en;
	assign en = !skid_v_q;
	assign point_stall = skid_v_q;

	// ---------------- stage 1: subtract camera center
	logic signed [DW-1:0] d_s1 [3];
	side_t                side_s1;
	logic                 v_s1;
	logic signed [31:0]   world [3];

	assign world[0] = point.world_x;
	assign world[1] = point.world_y;
	assign world[2] = point.world_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				d_s1[j] <= DW'(world[j]) - DW'($signed(center_q[j]));
			end
			side_s1.image_x <= point.image_x;
			side_s1.image_y <= point.image_y;
			side_s1.tag <= point.point_tag;
		end
	end

	// ---------------- stage 2: rotation products
	logic signed [MPW-1:0] prod_s2 [3][3];
	side_t                 side_s2;
	logic                  v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[r][j] <= $signed(rot_q[r][16*j +: 16]) * d_s1[j];
				end
			end
			side_s2 <= side_s1;
		end
	end

	// ---------------- stage 3: row sums
	logic signed [PW-1:0] p_s3 [3];
	side_t                side_s3;
	logic                 v_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				p_s3[r] <= PW'(prod_s2[r][0]) + PW'(prod_s2[r][1]) + PW'(prod_s2[r][2]);
			end
			side_s3 <= side_s2;
		end
	end

	// ---------------- stage 4: focal times lateral magnitude, partial products
	logic [63:0]     fl_s4 [2];
	logic [ZW-1:0]   fh_s4 [2];
	logic [1:0]      neg_s4;
	logic [ZW-1:0]   pz_s4;
	logic            behind_s4;
	side_t           side_s4;
	logic            v_s4;
	logic [PW-1:0]   lat_mag [2];

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			lat_mag[a] = p_s3[a][PW-1] ? PW'(-p_s3[a]) : PW'(p_s3[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 2; a++) begin
				fl_s4[a] <= 64'(focal_q[a]) * 64'(lat_mag[a][31:0]);
				fh_s4[a] <= ZW'(focal_q[a]) * ZW'(lat_mag[a][ZW-1:32]);
				neg_s4[a] <= p_s3[a][PW-1];
			end
			pz_s4 <= p_s3[2][ZW-1:0];
			// zero depth counts as behind
			behind_s4 <= p_s3[2][PW-1] || (p_s3[2] == '0);
			side_s4 <= side_s3;
		end
	end

	// ---------------- stage 5: assemble numerators
	logic [NW-1:0]   num_s5 [2];
	logic [1:0]      neg_s5;
	logic [ZW-1:0]   pz_s5;
	logic            behind_s5;
	side_t           side_s5;
	logic            v_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 2; a++) begin
				num_s5[a] <= (NW'(fh_s4[a]) << 32) + NW'(fl_s4[a]);
			end
			neg_s5 <= neg_s4;
			pz_s5 <= pz_s4;
			behind_s5 <= behind_s4;
			side_s5 <= side_s4;
		end
	end

	// ---------------- divider: entry stage, then one quotient bit per stage
	div_t          div_s [QB+1];
	logic [QB:0]   div_v;
	div_t          div_init;

	always_comb begin
		div_init.pz = pz_s5;
		div_init.behind = behind_s5;
		div_init.side = side_s5;
		div_init.neg = neg_s5;
		for (int a = 0; a < 2; a++) begin
			// quotient would reach the clamp when the top bits alone cover the depth
			div_init.ovf[a] = ZW'(num_s5[a][NW-1:QB]) >= pz_s5;
			div_init.rem[a] = ZW'(num_s5[a][NW-1:QB]);
			div_init.sh[a] = num_s5[a][QB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0] <= div_init;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_div
		div_t nxt;
		logic [ZW:0] trial [2];
		logic        ge [2];

		always_comb begin
			nxt = div_s[k];
			for (int a = 0; a < 2; a++) begin
				trial[a] = {div_s[k].rem[a], div_s[k].sh[a][QB-1]};
				ge[a] = trial[a] >= {1'b0, div_s[k].pz};
				nxt.rem[a] = ge[a] ? ZW'(trial[a] - {1'b0, div_s[k].pz}) : ZW'(trial[a]);
				nxt.sh[a] = {div_s[k].sh[a][QB-2:0], ge[a]};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				div_s[k+1] <= nxt;
			end
		end
	end

	// ---------------- stage 7: signed pixel error
	logic signed [EW-1:0] e_s7 [2];
	logic                 behind_s7;
	logic [15:0]          tag_s7;
	logic                 v_s7;
	logic [QB:0]          quot [2];
	logic signed [31:0]   img [2];

	assign img[0] = div_s[QB].side.image_x;
	assign img[1] = div_s[QB].side.image_y;

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			quot[a] = div_s[QB].ovf[a] ? {1'b1, {QB{1'b0}}} : {1'b0, div_s[QB].sh[a]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 2; a++) begin
				e_s7[a] <= div_s[QB].neg[a] ? EW'(img[a]) + $signed(EW'(quot[a]))
				                            : EW'(img[a]) - $signed(EW'(quot[a]));
			end
			behind_s7 <= div_s[QB].behind;
			tag_s7 <= div_s[QB].side.tag;
		end
	end

	// ---------------- stage 8: magnitude with clamp
	logic [CB:0]   m_s8 [2];
	logic          behind_s8;
	logic [15:0]   tag_s8;
	logic          v_s8;
	logic [EW-1:0] e_mag [2];

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			e_mag[a] = e_s7[a][EW-1] ? EW'(-e_s7[a]) : EW'(e_s7[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 2; a++) begin
				m_s8[a] <= (e_mag[a][EW-1:CB] != '0) ? {1'b1, {CB{1'b0}}} : e_mag[a][CB:0];
			end
			behind_s8 <= behind_s7;
			tag_s8 <= tag_s7;
		end
	end

	// ---------------- stage 9: square partial products
	logic [63:0]   bb_s9 [2];
	logic [CB:0]   ab_s9 [2];
	logic [2*(CB-31)-1:0] aa_s9 [2];
	logic          behind_s9;
	logic [15:0]   tag_s9;
	logic          v_s9;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 2; a++) begin
				bb_s9[a] <= 64'(m_s8[a][31:0]) * 64'(m_s8[a][31:0]);
				ab_s9[a] <= (CB+1)'(m_s8[a][CB:32]) * (CB+1)'(m_s8[a][31:0]);
				aa_s9[a] <= (2*(CB-31))'(m_s8[a][CB:32]) * (2*(CB-31))'(m_s8[a][CB:32]);
			end
			behind_s9 <= behind_s8;
			tag_s9 <= tag_s8;
		end
	end

	// ---------------- stage 10: squares
	logic [SQW-1:0] sq_s10 [2];
	logic           behind_s10;
	logic [15:0]    tag_s10;
	logic           v_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 2; a++) begin
				sq_s10[a] <= (SQW'(aa_s9[a]) << 64) + (SQW'(ab_s9[a]) << 33) + SQW'(bb_s9[a]);
			end
			behind_s10 <= behind_s9;
			tag_s10 <= tag_s9;
		end
	end

	// ---------------- stage 11: sum, scale, saturate
	pre_pkg::result_t res_s11;
	logic             v_s11;
	logic [TW-1:0]    tot;
	logic             sat;

	always_comb begin
		tot = TW'(sq_s10[0]) + TW'(sq_s10[1]);
		sat = (tot >> (64 + FRAC_BITS)) != '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s11.squared_error <= (sat || behind_s10) ? '1 : 64'(tot >> FRAC_BITS);
			res_s11.behind_camera <= behind_s10;
			res_s11.result_tag <= tag_s10;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			div_v <= '0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s1 <= point_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			div_v <= {div_v[QB-1:0], v_s5};
			v_s7 <= div_v[QB];
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// ---------------- output register and skid
	pre_pkg::result_t out_q;
	pre_pkg::result_t skid_q;
	logic             out_v_q;
	logic             take;

	assign take = out_v_q && !result_stall;
	assign result_valid = out_v_q;
	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (take) begin
				skid_v_q <= 1'b0;
			end
		end else if (v_s11) begin
			if (out_v_q && !take) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (take) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (take) begin
				out_q <= skid_q;
			end
		end else if (v_s11) begin
			if (out_v_q && !take) begin
				skid_q <= res_s11;
			end else begin
				out_q <= res_s11;
			end
		end
	end

endmodule

// ===== tb/pose_reprojection_error_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_reprojection_error_unit_test
// Streams correspondences through the unit under several camera poses,
// predicts each squared pixel error in wide integer arithmetic and checks
// every result in order, with random input gaps and output stalls.
// ----------------------------------------------------------------------------
module pose_reprojection_error_unit_test;

	localparam int FRAC = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 100;
	localparam logic [63:0] ERR_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [127:0] QUOT_CAP = 128'd1 << pre_pkg::QUOT_BITS;

	logic                           clk;
	logic                           arst_n;
	logic                           point_valid;
	logic                           point_stall;
	pre_pkg::point_t                point;
	logic                           result_valid;
	logic                           result_stall;
	pre_pkg::result_t               result;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [pre_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [pre_pkg::CFG_DATA_W-1:0] cfg_data;

	pose_reprojection_error_unit #(.FRAC_BITS(FRAC)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.point_valid(point_valid), .point_stall(point_stall), .point(point),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// pose mirror
	logic [47:0]        rot_row [3];
	logic signed [31:0] cam_center [3];
	logic [31:0]        focal [2];

	pre_pkg::point_t  pending_points [$];
	pre_pkg::result_t expected_errors [$];
	int      errors = 0;
	int      points_sent = 0;
	int      results_seen = 0;
	int      behind_seen = 0;
	int      saturated_seen = 0;
	int      cycle_count = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] axis_error(logic [31:0] f, longint num, longint den,
			logic signed [31:0] img);
		logic [127:0] prod, quot;
		logic [63:0]  mag;
		longint       u, e;
		mag = num < 0 ? 64'(-num) : 64'(num);
		prod = {96'd0, f} * {64'd0, mag};
		quot = prod / {64'd0, 64'(den)};
		if (quot > QUOT_CAP) quot = QUOT_CAP;
		u = num < 0 ? -longint'(quot[63:0]) : longint'(quot[63:0]);
		e = longint'(img) - u;
		return e < 0 ? 64'(-e) : 64'(e);
	endfunction

	function automatic pre_pkg::result_t predict_error(pre_pkg::point_t pt);
		longint           d [3];
		longint           cam [3];
		logic [127:0]     ex, ey, sum;
		pre_pkg::result_t r;
		d[0] = longint'(pt.world_x) - longint'(cam_center[0]);
		d[1] = longint'(pt.world_y) - longint'(cam_center[1]);
		d[2] = longint'(pt.world_z) - longint'(cam_center[2]);
		for (int i = 0; i < 3; i++) begin
			cam[i] = 0;
			for (int j = 0; j < 3; j++)
				cam[i] += longint'($signed(rot_row[i][16*j +: 16])) * d[j];
		end
		r.result_tag = pt.point_tag;
		// zero depth counts as behind
		if (cam[2] <= 0) begin
			r.squared_error = ERR_MAX;
			r.behind_camera = 1'b1;
		end else begin
			ex = {64'd0, axis_error(focal[0], cam[0], cam[2], pt.image_x)};
			ey = {64'd0, axis_error(focal[1], cam[1], cam[2], pt.image_y)};
			sum = ex * ex + ey * ey;
			r.behind_camera = 1'b0;
			r.squared_error = (sum[127:64+FRAC] != 0) ? ERR_MAX : sum[63+FRAC:FRAC];
		end
		return r;
	endfunction

	// sender: bursts with gaps, payload held while stalled
	int burst_left = 8;
	int gap_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			point_valid <= 1'b0;
			point <= '0;
		end else begin
			if (point_valid && !point_stall) begin
				expected_errors.insert(expected_errors.size(),
					predict_error(pending_points.pop_front()));
				points_sent++;
			end
			if (!point_valid || !point_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					point_valid <= 1'b0;
				end else if (pending_points.size() > 0) begin
					point <= pending_points[0];
					point_valid <= 1'b1;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					point_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall pattern switches among four modes
	int stall_mode = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles", $time, cycle_count);
			$display("pose_reprojection_error_unit verification failed");
			$finish;
		end
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_errors.size() == 0) begin
					$display("%0t unexpected item: actual %h", $time, result);
					errors++;
				end else begin
					pre_pkg::result_t want;
					want = expected_errors.pop_front();
					if (result.squared_error !== want.squared_error) begin
						$display("%0t squared_error: expected %h actual %h", $time,
							want.squared_error, result.squared_error);
						errors++;
					end
					if (result.behind_camera !== want.behind_camera) begin
						$display("%0t behind_camera: expected %b actual %b", $time,
							want.behind_camera, result.behind_camera);
						errors++;
					end
					if (result.result_tag !== want.result_tag) begin
						$display("%0t result_tag: expected %h actual %h", $time,
							want.result_tag, result.result_tag);
						errors++;
					end
					if (want.behind_camera) behind_seen++;
					else if (want.squared_error == ERR_MAX) saturated_seen++;
				end
			end
			if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: result_stall <= 1'b0;
				1: result_stall <= ($urandom_range(0, 9) < 3);
				2: result_stall <= ($urandom_range(0, 9) < 8);
				default: result_stall <= (cycle_count % 7) < 3;
			endcase
		end
	end

	task automatic write_reg(pre_pkg::cfg_reg_t idx, logic [47:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			pre_pkg::REG_ROT_ROW_0: rot_row[0] = value;
			pre_pkg::REG_ROT_ROW_1: rot_row[1] = value;
			pre_pkg::REG_ROT_ROW_2: rot_row[2] = value;
			pre_pkg::REG_CENTER_X:  cam_center[0] = value[31:0];
			pre_pkg::REG_CENTER_Y:  cam_center[1] = value[31:0];
			pre_pkg::REG_CENTER_Z:  cam_center[2] = value[31:0];
			pre_pkg::REG_FOCAL_X:   focal[0] = value[31:0];
			default:                focal[1] = value[31:0];
		endcase
	endtask

	task automatic set_pose(logic [47:0] r0, logic [47:0] r1, logic [47:0] r2,
			logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
			logic [31:0] fx, logic [31:0] fy);
		write_reg(pre_pkg::REG_ROT_ROW_0, r0);
		write_reg(pre_pkg::REG_ROT_ROW_1, r1);
		write_reg(pre_pkg::REG_ROT_ROW_2, r2);
		write_reg(pre_pkg::REG_CENTER_X, {16'd0, cx});
		write_reg(pre_pkg::REG_CENTER_Y, {16'd0, cy});
		write_reg(pre_pkg::REG_CENTER_Z, {16'd0, cz});
		write_reg(pre_pkg::REG_FOCAL_X, {16'd0, fx});
		write_reg(pre_pkg::REG_FOCAL_Y, {16'd0, fy});
	endtask

	task automatic drain();
		wait (pending_points.size() == 0 && expected_errors.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_point(pre_pkg::point_t pt);
		pending_points.insert(pending_points.size(), pt);
	endtask

	function automatic logic [31:0] near_offset(logic [31:0] base, int span_bits);
		return base + 32'($signed($urandom_range(0, (1 << span_bits) - 1))
			- (1 << (span_bits - 1)));
	endfunction

	function automatic pre_pkg::point_t random_point();
		pre_pkg::point_t pt;
		if ($urandom_range(0, 3) == 0) begin
			pt = {$urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom)};
		end else begin
			// points around the camera with a moderate pixel error
			pt.world_x = near_offset(cam_center[0], $urandom_range(4, 24));
			pt.world_y = near_offset(cam_center[1], $urandom_range(4, 24));
			pt.world_z = near_offset(cam_center[2], $urandom_range(4, 24));
			pt.image_x = near_offset(32'd0, $urandom_range(4, 31));
			pt.image_y = near_offset(32'd0, $urandom_range(4, 31));
			pt.point_tag = 16'($urandom);
		end
		return pt;
	endfunction

	function automatic logic [47:0] random_row();
		logic [47:0] row;
		row = {$urandom, $urandom};
		if ($urandom_range(0, 1)) begin
			for (int j = 0; j < 3; j++)
				row[16*j +: 16] = 16'($signed($urandom_range(0, 32767)) - 16384);
		end
		return row;
	endfunction

	task automatic random_points(int count);
		for (int i = 0; i < count; i++) add_point(random_point());
	endtask

	function automatic pre_pkg::point_t make_point(logic [31:0] wx, logic [31:0] wy,
			logic [31:0] wz, logic [31:0] ix, logic [31:0] iy, logic [15:0] tag);
		pre_pkg::point_t pt;
		pt.world_x = wx; pt.world_y = wy; pt.world_z = wz;
		pt.image_x = ix; pt.image_y = iy; pt.point_tag = tag;
		return pt;
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		rot_row[0] = pre_pkg::ROT_ROW_0_RST;
		rot_row[1] = pre_pkg::ROT_ROW_1_RST;
		rot_row[2] = pre_pkg::ROT_ROW_2_RST;
		cam_center[0] = 0; cam_center[1] = 0; cam_center[2] = 0;
		focal[0] = pre_pkg::FOCAL_RST; focal[1] = pre_pkg::FOCAL_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// reset pose: in front, zero depth, behind, extremes, saturation
		add_point(make_point(32'h0001_0000, 32'h0002_0000, 32'h0004_0000,
			32'h0000_4000, 32'h0000_8000, 16'h0000));
		add_point(make_point(32'h0001_0000, 32'h0001_0000, 32'h0,
			32'h0, 32'h0, 16'hFFFF));
		add_point(make_point(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000,
			32'h0, 32'h0, 16'h1234));
		add_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
			32'h7FFF_FFFF, 32'h8000_0000, 16'h8001));
		add_point(make_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFE));
		add_point(make_point(32'h0, 32'h0, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h5555));
		add_point(make_point(32'h0, 32'h0, 32'h8000_0000,
			32'h0, 32'h0, 16'hAAAA));
		add_point(make_point(32'h0, 32'h0, 32'h0000_0001,
			32'h0, 32'h0, 16'h0001));
		random_points(200);
		drain();

		// typical camera
		set_pose(pre_pkg::ROT_ROW_0_RST, pre_pkg::ROT_ROW_1_RST, pre_pkg::ROT_ROW_2_RST,
			32'h0010_0000, 32'hFFF0_0000, 32'hFF00_0000, 32'h01F4_0000, 32'h01F4_8000);
		add_point(make_point(32'h0010_0000, 32'hFFF0_0000, 32'hFF00_0000,
			32'h0, 32'h0, 16'h0002));
		random_points(200);
		drain();

		// extreme rotation entries, centre and focal lengths
		set_pose(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h7FFF_8000_7FFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
		add_point(make_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h0, 32'h0, 16'h0003));
		random_points(200);
		drain();

		// depth row zero: every point lands on zero depth
		set_pose(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 48'h0,
			32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF);
		random_points(60);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			set_pose(random_row(), random_row(), random_row(), $urandom, $urandom, $urandom,
				($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(1, 2000)) << 16,
				($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(1, 2000)) << 16);
			random_points(175);
			drain();
		end

		if (expected_errors.size() != 0) begin
			$display("%0t %0d expected items never arrived", $time, expected_errors.size());
			errors++;
		end
		$display("sent %0d points over 10 poses, checked %0d results", points_sent,
			results_seen);
		$display("%0d behind the camera, %0d saturated, %0d mismatches", behind_seen,
			saturated_seen, errors);
		if (errors == 0) begin
			$display("pose_reprojection_error_unit verification clean");
		end else begin
			$display("pose_reprojection_error_unit verification failed");
		end
		$finish;
	end

endmodule

// ===== pose_reprojection_error_unit.f =====
sv/pre_pkg.sv
sv/pose_reprojection_error_unit.sv
tb/pose_reprojection_error_unit_test.sv
